FILE: sv/ucs_pkg.sv
// Shared types, constants and per-byte helper functions for the URI component splitter.
package ucs_pkg;

   localparam int unsigned MAX_LEN = 4096;
   localparam int unsigned POS_W   = 13;
   localparam int unsigned VAL_W   = 17;

   localparam logic [POS_W-1:0] MAX_POS  = POS_W'(MAX_LEN);
   localparam logic [VAL_W-1:0] VAL_SAT  = VAL_W'(65536);
   localparam logic [VAL_W-1:0] VAL_MAXP = VAL_W'(16'hFFFF);

   localparam logic [7:0] CH_QUERY = 8'h3F;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   typedef enum logic [2:0] {
      PH_EMPTY  = 3'd0,
      PH_SPACE  = 3'd1,
      PH_PLUS   = 3'd2,
      PH_MINUS  = 3'd3,
      PH_DIG    = 3'd4,
      PH_NEGDIG = 3'd5,
      PH_ERR    = 3'd6
   } port_phase_type;

   // One reading of the authority: either from offset zero or past "scheme://".
   typedef struct packed {
      logic             slash_found;
      logic [POS_W-1:0] slash_at;
      logic             colon_found;
      logic [POS_W-1:0] colon_at;
      logic [VAL_W-1:0] port_value;
      port_phase_type   port_phase;
   } reading_type;

   localparam reading_type READING_RESET = '{
      slash_found: 1'b0, slash_at: '0, colon_found: 1'b0, colon_at: '0,
      port_value: '0, port_phase: PH_EMPTY
   };

   // Result packed from the lowest bit up: uri_valid, has_scheme, scheme_end,
   // host_start, host_end, has_port, port_number, path_start, query_start,
   // uri_length, zero padding.
   typedef struct packed {
      logic [6:0]       pad;
      logic [POS_W-1:0] uri_length;
      logic [POS_W-1:0] query_start;
      logic [POS_W-1:0] path_start;
      logic [15:0]      port_number;
      logic             has_port;
      logic [POS_W-1:0] host_end;
      logic [POS_W-1:0] host_start;
      logic [POS_W-1:0] scheme_end;
      logic             has_scheme;
      logic             uri_valid;
   } result_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

   // Feeds one byte of port text, following integer parsing with optional
   // leading whitespace and sign.
   function automatic reading_type port_feed(input reading_type rd, input logic [7:0] b);
      reading_type      r;
      logic [19:0]      prod;
      logic [VAL_W-1:0] digit;
      r     = rd;
      digit = VAL_W'(b - CH_ZERO);
      prod  = 20'({3'b000, rd.port_value} * 20'd10) + 20'(digit);
      if (rd.port_phase != PH_ERR) begin
         if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
            if ((rd.port_phase == PH_DIG) || (rd.port_phase == PH_NEGDIG)) begin
               r.port_value = (prod > 20'(VAL_SAT)) ? VAL_SAT : prod[VAL_W-1:0];
            end else begin
               r.port_value = digit;
               r.port_phase = (rd.port_phase == PH_MINUS) ? PH_NEGDIG : PH_DIG;
            end
         end else if (is_space(b)) begin
            r.port_phase = ((rd.port_phase == PH_EMPTY) || (rd.port_phase == PH_SPACE)) ?
                           PH_SPACE : PH_ERR;
         end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
            if ((rd.port_phase == PH_EMPTY) || (rd.port_phase == PH_SPACE)) begin
               r.port_phase = (b == CH_PLUS) ? PH_PLUS : PH_MINUS;
            end else begin
               r.port_phase = PH_ERR;
            end
         end else begin
            r.port_phase = PH_ERR;
         end
      end
      return r;
   endfunction

   // One byte of host, port or path text for one reading, before the query.
   function automatic reading_type track(input reading_type rd, input logic [7:0] b,
                                         input logic [POS_W-1:0] p);
      reading_type r;
      r = rd;
      if (!rd.slash_found) begin
         if (b == CH_SLASH) begin
            r.slash_found = 1'b1;
            r.slash_at    = p;
         end else if (!rd.colon_found) begin
            if (b == CH_COLON) begin
               r.colon_found = 1'b1;
               r.colon_at    = p;
            end
         end else begin
            r = port_feed(rd, b);
         end
      end
      return r;
   endfunction

endpackage

FILE: sv/uri_component_splitter.sv
// Top level of the URI component splitter: byte stream in, component boundaries out.
//
// The request channel (req_) carries one nonzero URI byte per request in
// req_tdata, with req_tlast marking the final byte of a URI. For each URI one
// result leaves on the rsp_ channel after its last byte: the validity flag,
// scheme, host, port, path and query boundaries, the port value and the length.
// A byte is registered on acceptance and folded into the parse state as it
// leaves that register; the result register is loaded in that same cycle, so a
// result is offered once its last byte is folded in. One byte is accepted in every
// cycle unless a last byte waits for the result register. A stalled result holds
// in its register while bytes of the next URI keep flowing; only a second last
// byte waits until the result is taken. Bytes past 4096 are counted as overflow
// and make the result invalid. Synchronous reset empties both registers and
// returns the parse state to the start of a URI; no clearing pass is needed.
module uri_component_splitter
   import ucs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // char_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata    // uri_valid, has_scheme, scheme_end, host_start,
                                     // host_end, has_port, port_number, path_start,
                                     // query_start, uri_length, zero padding
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_char_ff;
   logic             in_last_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff, rsp_data_in;

   logic [POS_W-1:0] position_ff, position_in;
   logic             too_long_ff, too_long_in;
   logic             query_seen_ff, query_seen_in;
   logic [POS_W-1:0] query_offset_ff, query_offset_in;
   logic             colon_seen_ff, colon_seen_in;
   logic [POS_W-1:0] colon_offset_ff, colon_offset_in;
   logic [1:0]       slash_count_ff, slash_count_in;
   logic             scheme_dropped_ff, scheme_dropped_in;
   reading_type      plain_ff, plain_in;
   reading_type      schemed_ff, schemed_in;

   logic             advance;
   logic             out_free;

   logic [POS_W-1:0] u_position;
   logic             u_too_long;
   logic             u_query_seen;
   logic [POS_W-1:0] u_query_offset;
   logic             u_colon_seen;
   logic [POS_W-1:0] u_colon_offset;
   logic [1:0]       u_slash_count;
   logic             u_dropped;
   reading_type      u_plain;
   reading_type      u_schemed;

   logic             sch;
   reading_type      sel;
   logic [POS_W-1:0] qs, ps, he;
   logic             ok;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Fold the registered byte into the parse state.
   always_comb begin
      u_position     = position_ff;
      u_too_long     = too_long_ff;
      u_query_seen   = query_seen_ff;
      u_query_offset = query_offset_ff;
      u_colon_seen   = colon_seen_ff;
      u_colon_offset = colon_offset_ff;
      u_slash_count  = slash_count_ff;
      u_dropped      = scheme_dropped_ff;
      u_plain        = plain_ff;
      u_schemed      = schemed_ff;
      if (position_ff >= MAX_POS) begin
         u_too_long = 1'b1;
      end else begin
         u_position = position_ff + POS_W'(1);
         if (colon_seen_ff && !scheme_dropped_ff && (slash_count_ff != 2'd3)) begin
            if (slash_count_ff != 2'd2) begin
               if (in_char_ff == CH_SLASH) begin
                  u_slash_count = slash_count_ff + 2'd1;
               end else begin
                  u_dropped = 1'b1;
               end
            end else begin
               u_slash_count = 2'd3;
            end
         end
         if (!query_seen_ff) begin
            if (in_char_ff == CH_QUERY) begin
               u_query_seen   = 1'b1;
               u_query_offset = position_ff;
            end else begin
               if ((in_char_ff == CH_COLON) && !colon_seen_ff) begin
                  u_colon_seen   = 1'b1;
                  u_colon_offset = position_ff;
               end
               u_plain = track(plain_ff, in_char_ff, position_ff);
               if (u_colon_seen && !u_dropped && (u_slash_count == 2'd3)) begin
                  u_schemed = track(schemed_ff, in_char_ff, position_ff);
               end
            end
         end
      end
   end

   // Result from the state that includes the final byte.
   always_comb begin
      sch = u_colon_seen && !u_dropped && (u_slash_count == 2'd3);
      sel = sch ? u_schemed : u_plain;
      qs  = u_query_seen ? u_query_offset : u_position;
      ps  = sel.slash_found ? sel.slash_at : qs;
      he  = sel.colon_found ? sel.colon_at : ps;
      case (sel.port_phase)
         PH_EMPTY:  ok = 1'b1;
         PH_DIG:    ok = (sel.port_value <= VAL_MAXP);
         PH_NEGDIG: ok = (sel.port_value == '0);
         default:   ok = 1'b0;
      endcase
      rsp_data_in = '0;
      if (u_too_long) begin
         rsp_data_in.uri_length = MAX_POS;
      end else begin
         rsp_data_in.uri_valid   = ok;
         rsp_data_in.has_scheme  = sch;
         rsp_data_in.scheme_end  = sch ? u_colon_offset : '0;
         rsp_data_in.host_start  = sch ? (u_colon_offset + POS_W'(3)) : '0;
         rsp_data_in.host_end    = he;
         rsp_data_in.has_port    = sel.colon_found;
         rsp_data_in.port_number = (ok && (sel.port_phase != PH_EMPTY)) ?
                                   sel.port_value[15:0] : 16'd0;
         rsp_data_in.path_start  = ps;
         rsp_data_in.query_start = qs;
         rsp_data_in.uri_length  = u_position;
      end
   end

   always_comb begin
      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      position_in       = position_ff;
      too_long_in       = too_long_ff;
      query_seen_in     = query_seen_ff;
      query_offset_in   = query_offset_ff;
      colon_seen_in     = colon_seen_ff;
      colon_offset_in   = colon_offset_ff;
      slash_count_in    = slash_count_ff;
      scheme_dropped_in = scheme_dropped_ff;
      plain_in          = plain_ff;
      schemed_in        = schemed_ff;
      if (advance) begin
         if (in_last_ff) begin
            position_in       = '0;
            too_long_in       = 1'b0;
            query_seen_in     = 1'b0;
            query_offset_in   = '0;
            colon_seen_in     = 1'b0;
            colon_offset_in   = '0;
            slash_count_in    = 2'd0;
            scheme_dropped_in = 1'b0;
            plain_in          = READING_RESET;
            schemed_in        = READING_RESET;
         end else begin
            position_in       = u_position;
            too_long_in       = u_too_long;
            query_seen_in     = u_query_seen;
            query_offset_in   = u_query_offset;
            colon_seen_in     = u_colon_seen;
            colon_offset_in   = u_colon_offset;
            slash_count_in    = u_slash_count;
            scheme_dropped_in = u_dropped;
            plain_in          = u_plain;
            schemed_in        = u_schemed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         position_ff       <= '0;
         too_long_ff       <= 1'b0;
         query_seen_ff     <= 1'b0;
         query_offset_ff   <= '0;
         colon_seen_ff     <= 1'b0;
         colon_offset_ff   <= '0;
         slash_count_ff    <= 2'd0;
         scheme_dropped_ff <= 1'b0;
         plain_ff          <= READING_RESET;
         schemed_ff        <= READING_RESET;
      end else begin
         in_valid_ff       <= in_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         position_ff       <= position_in;
         too_long_ff       <= too_long_in;
         query_seen_ff     <= query_seen_in;
         query_offset_ff   <= query_offset_in;
         colon_seen_ff     <= colon_seen_in;
         colon_offset_ff   <= colon_offset_in;
         slash_count_ff    <= slash_count_in;
         scheme_dropped_ff <= scheme_dropped_in;
         plain_ff          <= plain_in;
         schemed_ff        <= schemed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_last_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
